@@ sv/tcddc_pkg.sv @@
// Package for the time-of-flight clock drift distance corrector.
// Holds the payload structs, controller/datapath handshake structs and shared constants.
// No dependencies.
package tcddc_pkg;

  // Default configuration handed to the top-level parameters.
  localparam int unsigned WINDOW_DEPTH_DEF    = 5;
  localparam int unsigned RATIO_FRAC_BITS_DEF = 14;

  // Field widths.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned STAT_W  = 8;

  // Host milliseconds to module ticks (0.2 us) and the widths that follow from it.
  localparam int unsigned HOST_TICK_SCALE   = 5000;
  localparam int unsigned HOST_TICK_SCALE_W = 13;
  localparam int unsigned NUM_W             = TIME_W + HOST_TICK_SCALE_W;
  localparam int unsigned NUM10_W           = NUM_W + 4;
  localparam int unsigned MD7_W             = TIME_W + 3;
  localparam int unsigned MD13_W            = TIME_W + 4;

  localparam logic [STAT_W-1:0] VALID_STATUS = 8'h55;
  localparam logic [DIST_W-1:0] DIST_MAX     = 16'hFFFF;

  localparam logic OPC_FRAME   = 1'b0;
  localparam logic OPC_RESTART = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [STAT_W-1:0] status_code;
    logic [ID_W-1:0]   frame_id;
    logic [TIME_W-1:0] module_clock;
    logic [DIST_W-1:0] raw_distance_mm;
    logic [TIME_W-1:0] host_time_ms;
  } tcddc_in_t;

  typedef struct packed {
    logic              ready_res;
    logic [DIST_W-1:0] distance_mm;
  } tcddc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear;
    logic push;
    logic slide;
    logic scale;
    logic div_start;
    logic div_step;
    logic mul;
    logic load_out;
    logic res_ok;
  } tcddc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_restart;
    logic frame_ok;
    logic window_full;
    logic ratio_ok;
    logic div_last;
    logic out_free;
  } tcddc_sts_t;

endpackage

@@ sv/tcddc_datapath.sv @@
// Datapath of the clock drift corrector: time window, ratio estimate, serial divider,
// distance scaling and the output register.
// Depends on tcddc_pkg.
module tcddc_datapath import tcddc_pkg::*; #(
  parameter int unsigned WindowDepth   = WINDOW_DEPTH_DEF,
  parameter int unsigned RatioFracBits = RATIO_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tcddc_in_t  in_data_i,
  input  tcddc_cmd_t cmd_i,
  output tcddc_sts_t sts_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output tcddc_out_t out_data_o
);

  localparam int unsigned Slots  = WindowDepth - 1;
  localparam int unsigned FillW  = $clog2(WindowDepth);
  localparam int unsigned RatioW = RatioFracBits + 2;
  localparam int unsigned CntW   = $clog2(RatioW);
  localparam int unsigned ProdW  = DIST_W + RatioW;

  tcddc_in_t             item_q;
  logic [ID_W-1:0]       last_id_q;
  logic [FillW-1:0]      fill_q;
  logic [TIME_W-1:0]     win_h_q [Slots];
  logic [TIME_W-1:0]     win_m_q [Slots];
  logic [TIME_W-1:0]     hd_q, md_q;
  logic                  mono_q;
  logic [NUM_W-1:0]      num_q;
  logic [MD7_W-1:0]      md7_q;
  logic [MD13_W-1:0]     md13_q;
  logic [TIME_W-1:0]     rem_q;
  logic [RatioW-1:0]     nbits_q;
  logic [RatioW-1:0]     quo_q;
  logic [CntW-1:0]       cnt_q;
  logic [RatioW-1:0]     ratio_q;
  logic [ProdW-1:0]      prod_q;
  logic                  out_valid_q;
  tcddc_out_t            out_data_q;

  logic [NUM10_W-1:0]    num10;
  logic [TIME_W:0]       trial, diff;
  logic                  ge;
  logic [ProdW-RatioFracBits-1:0] scaled;
  logic [DIST_W-1:0]     dist_sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // Window slots; the oldest pair sits in slot 0 once the window is full.
  for (genvar k = 0; k < Slots; k++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        win_h_q[k] <= '0;
        win_m_q[k] <= '0;
      end else if (cmd_i.clear) begin
        win_h_q[k] <= '0;
        win_m_q[k] <= '0;
      end else if (cmd_i.push && (fill_q == FillW'(k))) begin
        win_h_q[k] <= item_q.host_time_ms;
        win_m_q[k] <= item_q.module_clock;
      end else if (cmd_i.slide) begin
        if (k == Slots - 1) begin
          win_h_q[k] <= item_q.host_time_ms;
          win_m_q[k] <= item_q.module_clock;
        end else begin
          win_h_q[k] <= win_h_q[k+1];
          win_m_q[k] <= win_m_q[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_id_q <= '0;
      fill_q    <= '0;
      ratio_q   <= RatioW'(1) << RatioFracBits;
    end else if (cmd_i.clear) begin
      last_id_q <= '0;
      fill_q    <= '0;
      ratio_q   <= RatioW'(1) << RatioFracBits;
    end else begin
      if (cmd_i.push) begin
        fill_q    <= fill_q + FillW'(1);
        last_id_q <= item_q.frame_id;
      end
      if (cmd_i.slide) begin
        last_id_q <= item_q.frame_id;
      end
      if (cmd_i.div_step && (cnt_q == '0)) begin
        ratio_q <= {quo_q[RatioW-2:0], ge};
      end
    end
  end

  // Ratio estimate: deltas, scaling to ticks, range test and restoring division.
  assign num10 = (NUM10_W'(num_q) << 3) + (NUM10_W'(num_q) << 1);
  assign trial = {rem_q, nbits_q[RatioW-1]};
  assign diff  = trial - {1'b0, md_q};
  assign ge    = (trial >= {1'b0, md_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.slide) begin
      hd_q   <= item_q.host_time_ms - win_h_q[0];
      md_q   <= item_q.module_clock - win_m_q[0];
      mono_q <= (item_q.module_clock > win_m_q[0]) && (item_q.host_time_ms >= win_h_q[0]);
    end
    if (cmd_i.scale) begin
      num_q  <= NUM_W'(hd_q) * NUM_W'(HOST_TICK_SCALE);
      md7_q  <= (MD7_W'(md_q) << 3) - MD7_W'(md_q);
      md13_q <= (MD13_W'(md_q) << 3) + (MD13_W'(md_q) << 2) + MD13_W'(md_q);
    end
    if (cmd_i.div_start) begin
      // The range test bounds the quotient below 2^(RatioW), so the top part is below md.
      rem_q   <= num_q[TIME_W+1:2];
      nbits_q <= {num_q[1:0], {RatioFracBits{1'b0}}};
      quo_q   <= '0;
      cnt_q   <= CntW'(RatioW - 1);
    end else if (cmd_i.div_step) begin
      rem_q   <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      nbits_q <= nbits_q << 1;
      quo_q   <= {quo_q[RatioW-2:0], ge};
      cnt_q   <= cnt_q - CntW'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(item_q.raw_distance_mm) * ProdW'(ratio_q);
    end
  end

  assign scaled   = prod_q[ProdW-1:RatioFracBits];
  assign dist_sat = (|scaled[ProdW-RatioFracBits-1:DIST_W]) ? DIST_MAX : scaled[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q.ready_res   <= cmd_i.res_ok;
      out_data_q.distance_mm <= cmd_i.res_ok ? dist_sat : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    sts_o.is_restart  = (item_q.opcode == OPC_RESTART);
    sts_o.frame_ok    = (item_q.status_code == VALID_STATUS) && (item_q.frame_id != last_id_q);
    sts_o.window_full = (fill_q == FillW'(Slots));
    sts_o.ratio_ok    = mono_q && (num10 >= NUM10_W'(md7_q)) && (num10 <= NUM10_W'(md13_q));
    sts_o.div_last    = (cnt_q == '0);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

@@ sv/tcddc_ctrl.sv @@
// Controller of the clock drift corrector: sequences one frame through the datapath.
// Depends on tcddc_pkg.
module tcddc_ctrl import tcddc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tcddc_sts_t sts_i,
  output tcddc_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCALE  = 3'd2;
  localparam logic [2:0] S_RANGE  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;
  localparam logic [2:0] S_NULL   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.is_restart) begin
          cmd_o.clear = 1'b1;
          state_d     = S_NULL;
        end else if (!sts_i.frame_ok) begin
          state_d = S_NULL;
        end else if (sts_i.window_full) begin
          cmd_o.slide = 1'b1;
          state_d     = S_SCALE;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_RANGE;
      end
      S_RANGE: begin
        if (sts_i.ratio_ok) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_MUL;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_ok   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_NULL: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/tof_clock_drift_distance_corrector_core.sv @@
// Top level of the time-of-flight clock drift distance corrector.
// Instantiates tcddc_ctrl and tcddc_datapath; depends on tcddc_pkg.
//
//  Channel  | Signals                              | Carries
//  ---------+--------------------------------------+-----------------------------------
//  input    | in_valid_i, in_ready_o, in_data_i    | one result frame or a restart
//  output   | out_valid_o, out_ready_i, out_data_o | ready flag and corrected distance
//
// One frame is in work at a time. A restart or a rejected frame goes from decode straight to
// the result stage, a frame that still fills the window goes on to the multiply, and a frame
// on a full window is first scaled and range-tested and, if its ratio is accepted, divided by
// the serial divider, producing one quotient bit a cycle. A finished result waits in the
// output register while the next frame is taken in; a stalled output holds back only the
// completion of that next frame. Reset is asynchronous and needs no clearing pass.
module tof_clock_drift_distance_corrector_core import tcddc_pkg::*; #(
  parameter int unsigned WindowDepth   = WINDOW_DEPTH_DEF,
  parameter int unsigned RatioFracBits = RATIO_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tcddc_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output tcddc_out_t out_data_o
);

  tcddc_cmd_t cmd;
  tcddc_sts_t sts;

  tcddc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcddc_datapath #(
    .WindowDepth   (WindowDepth),
    .RatioFracBits (RatioFracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ verif/tof_clock_drift_distance_corrector_core_tb.sv @@
`timescale 1ns / 1ps

// Self-checking testbench for tof_clock_drift_distance_corrector_core.
// Sends result frames and restarts over valid/ready and checks each output against a
// scoreboard that tracks the time window and drift ratio; depends on tcddc_pkg only.

import tcddc_pkg::*;

class drift_scoreboard;
  bit [ID_W-1:0]   last_id;
  int unsigned     fill;
  bit [TIME_W-1:0] host_win [WINDOW_DEPTH_DEF];
  bit [TIME_W-1:0] tick_win [WINDOW_DEPTH_DEF];
  bit [15:0]       ratio_q;
  tcddc_out_t      expected_outputs [$];
  int unsigned     mismatch_count;

  function new();
    mismatch_count = 0;
    clear_window();
  endfunction

  function void clear_window();
    last_id = '0;
    fill    = 0;
    foreach (host_win[i]) begin
      host_win[i] = '0;
      tick_win[i] = '0;
    end
    ratio_q = 16'(1 << RATIO_FRAC_BITS_DEF);
  endfunction

  // The ratio only moves when both clocks advanced and the result is plausible.
  function void refit_ratio(bit [TIME_W-1:0] h0, bit [TIME_W-1:0] h1,
                            bit [TIME_W-1:0] m0, bit [TIME_W-1:0] m1);
    bit [63:0] host_delta;
    bit [63:0] tick_delta;
    bit [63:0] scaled_host;
    if (m1 <= m0 || h1 < h0) return;
    host_delta  = 64'(h1 - h0);
    tick_delta  = 64'(m1 - m0);
    scaled_host = host_delta * HOST_TICK_SCALE;
    if (scaled_host * 10 < tick_delta * 7 || scaled_host * 10 > tick_delta * 13) return;
    ratio_q = 16'((scaled_host << RATIO_FRAC_BITS_DEF) / tick_delta);
  endfunction

  function void note_frame(tcddc_in_t fr);
    tcddc_out_t res;
    bit [63:0]  scaled;
    res = '0;
    if (fr.opcode == OPC_RESTART) begin
      clear_window();
    end else if (fr.status_code == VALID_STATUS && fr.frame_id != last_id) begin
      last_id = fr.frame_id;
      if (fill < WINDOW_DEPTH_DEF - 1) begin
        host_win[fill] = fr.host_time_ms;
        tick_win[fill] = fr.module_clock;
        fill++;
      end else begin
        host_win[WINDOW_DEPTH_DEF-1] = fr.host_time_ms;
        tick_win[WINDOW_DEPTH_DEF-1] = fr.module_clock;
        refit_ratio(host_win[0], fr.host_time_ms, tick_win[0], fr.module_clock);
        for (int i = 0; i < WINDOW_DEPTH_DEF - 1; i++) begin
          host_win[i] = host_win[i+1];
          tick_win[i] = tick_win[i+1];
        end
      end
      scaled = (64'(fr.raw_distance_mm) * 64'(ratio_q)) >> RATIO_FRAC_BITS_DEF;
      res.ready_res   = 1'b1;
      res.distance_mm = (scaled > 64'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
    end
    expected_outputs.push_back(res);
  endfunction

  task report(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task check_output(tcddc_out_t got);
    tcddc_out_t want;
    if (expected_outputs.size() == 0) begin
      report($sformatf("result with nothing outstanding: ready=%0b distance=%0d",
                       got.ready_res, got.distance_mm));
      return;
    end
    want = expected_outputs.pop_front();
    if (got.ready_res !== want.ready_res)
      report($sformatf("ready_res %0b, expected %0b", got.ready_res, want.ready_res));
    if (got.distance_mm !== want.distance_mm)
      report($sformatf("distance_mm %0d, expected %0d", got.distance_mm, want.distance_mm));
  endtask

  function int unsigned pending();
    return expected_outputs.size();
  endfunction
endclass

module tof_clock_drift_distance_corrector_core_tb;
  localparam int unsigned RANDOM_FRAMES = 1005;
  localparam int unsigned PHASES        = 3;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam bit [31:0]   BASE_HOST     = 32'd1000;
  localparam bit [31:0]   BASE_TICKS    = 32'd100000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  tcddc_in_t  in_data   = '0;
  logic       in_ready;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tcddc_out_t out_data;

  int unsigned sender_gap_pct     = 11;
  int unsigned receiver_stall_pct = 83;
  bit          hold_req           = 1'b0;
  int unsigned cycle_count        = 0;

  bit [31:0]   gen_host;
  bit [31:0]   gen_ticks;
  bit [7:0]    gen_id;
  int unsigned drift_permille;

  drift_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tof_clock_drift_distance_corrector_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_data);
  end

  // Output side: random stalls, plus one long hold-off so that the block backs up.
  initial begin : receiver
    bit hold_served;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  function automatic tcddc_in_t mk_frame(logic op, logic [7:0] st, logic [7:0] id,
                                         logic [31:0] ticks, logic [15:0] dist_mm,
                                         logic [31:0] host);
    tcddc_in_t fr;
    fr.opcode          = op;
    fr.status_code     = st;
    fr.frame_id        = id;
    fr.module_clock    = ticks;
    fr.raw_distance_mm = dist_mm;
    fr.host_time_ms    = host;
    return fr;
  endfunction

  task automatic push_frame(input tcddc_in_t fr);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= fr;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(fr);
  endtask

  task automatic run_directed();
    push_frame(mk_frame(OPC_RESTART, 8'h00, 8'd0, 32'd0, 16'd0, 32'd0));
    // Id zero matches the cleared last id, so it is dropped as a repeat.
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd0, BASE_TICKS, 16'd500, BASE_HOST));
    push_frame(mk_frame(OPC_FRAME, 8'h54, 8'd1, BASE_TICKS, 16'd500, BASE_HOST));
    push_frame(mk_frame(OPC_FRAME, 8'hFF, 8'd1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd1, BASE_TICKS, 16'd0, BASE_HOST));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd1, BASE_TICKS + 5000, 16'd777,
                        BASE_HOST + 1));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd2, BASE_TICKS + 50000, 16'hFFFF,
                        BASE_HOST + 10));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd3, BASE_TICKS + 100000, 16'd1000,
                        BASE_HOST + 20));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd4, BASE_TICKS + 150000, 16'd1000,
                        BASE_HOST + 30));
    // Window full: ratio 1.2, and a full-scale distance saturates.
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd5, BASE_TICKS + 200000, 16'hFFFF,
                        BASE_HOST + 48));
    // Exactly 0.7, then exactly 1.3; both lie inside the accepted band.
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd6, BASE_TICKS + 100000, 16'd50000,
                        BASE_HOST + 17));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd7, BASE_TICKS + 150000, 16'd60000,
                        BASE_HOST + 33));
    // Just above 1.3 and just below 0.7: the ratio must stay put.
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd8, BASE_TICKS + 199999, 16'd40000,
                        BASE_HOST + 43));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd9, BASE_TICKS + 250001, 16'd12345,
                        BASE_HOST + 55));
    // Module clock flat, host time falling, module clock wrapped to zero.
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd10, BASE_TICKS + 100000, 16'd2222,
                        BASE_HOST + 100));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd11, BASE_TICKS + 300000, 16'd3333,
                        BASE_HOST + 32));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd12, 32'd0, 16'd4444, 32'hFFFF_FFFF));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd255, 32'hFFFF_FFFF, 16'd30000,
                        BASE_HOST + 55 + 858000));
    push_frame(mk_frame(OPC_RESTART, 8'h00, 8'd0, 32'd0, 16'd0, 32'd0));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd0, 32'd42, 16'd100, 32'd43));
    push_frame(mk_frame(OPC_FRAME, VALID_STATUS, 8'd7, 32'd42, 16'hFFFF, 32'd43));
    push_frame(mk_frame(OPC_RESTART, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  // Mostly a steady stream of good frames at the current drift, with restarts,
  // junk, repeated ids and jumps in either clock mixed in.
  task automatic send_random(output bit counted);
    int unsigned pick;
    int unsigned step_ms;
    bit [15:0]   dist_mm;
    tcddc_in_t   fr;
    pick    = $urandom_range(99);
    dist_mm = 16'($urandom_range(65535));
    counted = 1'b1;
    if ($urandom_range(9) == 0) dist_mm = 16'hFFFF;
    else if ($urandom_range(19) == 0) dist_mm = 16'd0;
    if (pick < 3) begin
      fr = mk_frame(OPC_RESTART, 8'($urandom), 8'($urandom), $urandom, dist_mm, $urandom);
    end else if (pick < 10) begin
      counted = 1'b0;
      fr = mk_frame(OPC_FRAME, ($urandom_range(3) == 0) ? VALID_STATUS : 8'($urandom),
                    8'($urandom), $urandom, dist_mm, $urandom);
    end else if (pick < 14) begin
      counted = 1'b0;
      fr = mk_frame(OPC_FRAME, VALID_STATUS, gen_id, gen_ticks, dist_mm, gen_host);
    end else begin
      gen_id++;
      step_ms   = $urandom_range(2000, 1);
      gen_host  += step_ms;
      gen_ticks += step_ms * 5 * drift_permille + $urandom_range(2000) - 1000;
      if (pick < 17) begin
        if ($urandom_range(1) == 1) gen_host = $urandom;
        else gen_ticks = $urandom;
      end
      fr = mk_frame(OPC_FRAME, VALID_STATUS, gen_id, gen_ticks, dist_mm, gen_host);
    end
    push_frame(fr);
  endtask

  initial begin : stimulus
    int unsigned counted_total;
    int unsigned phase_done;
    bit          counted;
    counted_total = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    gen_id         = 8'd7;
    gen_host       = $urandom;
    gen_ticks      = $urandom;
    drift_permille = 1000;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 1) begin
        sender_gap_pct = 83;
        receiver_stall_pct <= 11;
      end else if (phase == 2) begin
        sender_gap_pct = 0;
        receiver_stall_pct <= 0;
        hold_req <= 1'b1;
      end
      phase_done = 0;
      while (phase_done < RANDOM_FRAMES / PHASES) begin
        if (counted_total % 25 == 0) drift_permille = $urandom_range(1500, 600);
        send_random(counted);
        if (counted) begin
          phase_done++;
          counted_total++;
        end
      end
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
